// ===== hdl/flow_table_ttl_dedup_defines.svh =====
// Assertion macros for the flow table with idle aging.
`ifndef FLOW_TABLE_TTL_DEDUP_DEFINES_SVH
`define FLOW_TABLE_TTL_DEDUP_DEFINES_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define FTD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("flow table assertion failed");

// Consequent holds in the cycle after the antecedent.
`define FTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("flow table assertion failed");

`else

`define FTD_ASSERT(lbl, prop)
`define FTD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/ftd_pkg.sv =====
// Types and constants shared by the flow table modules.
package ftd_pkg;

  localparam int unsigned TtlWidth = 31;
  localparam logic [TtlWidth-1:0] TtlReset = 31'd300000;
  localparam int unsigned SlotWidth = 8;

  // One packet item
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  ip_protocol;
    logic [31:0] now_time;
  } flow_in_t;

  // One result item
  typedef struct packed {
    logic                 new_flow;
    logic [SlotWidth-1:0] slot_index;
    logic                 overwrote_live;
  } flow_out_t;

  // One table word
  typedef struct packed {
    logic        valid;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] port_pair;
    logic [7:0]  protocol;
    logic [31:0] seen_tick;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ftd_state_e;

endpackage

// ===== hdl/flow_table_ttl_dedup.sv =====
// Five-tuple flow table with idle aging: sequencer, compare unit and table RAM.
`include "flow_table_ttl_dedup_defines.svh"

// Each item accepted on start_i walks the whole table through a single RAM read
// port, one entry per cycle: an entry past its idle lifetime is invalidated,
// and the first live entry matching the five-tuple is refreshed. At the end a
// miss inserts the tuple in the lowest free slot, or in slot 0 when the table
// is full. The result appears on result_o for exactly one cycle, marked by
// result_valid_o, once the walk over every entry is done, and it cannot be held
// off; busy_o stays high from acceptance through the result, so the next item is
// taken only after the previous one is finished. After reset a clearing pass
// marks every entry empty; busy_o is high throughout. ttl may be written while
// busy_o is low.
module flow_table_ttl_dedup
  import ftd_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  flow_in_t            item_i,
  output logic                result_valid_o,
  output flow_out_t           result_o,
  input  logic                cfg_we_i,
  input  logic [TtlWidth-1:0] cfg_wdata_i
);

  localparam int unsigned AddrWidth = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntWidth  = AddrWidth + 1;
  localparam logic [CntWidth-1:0] CntEnd  = CntWidth'(TABLE_ENTRIES);
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(TABLE_ENTRIES - 1);

  ftd_state_e           state_q, state_d;
  logic [CntWidth-1:0]  cnt_q, cnt_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [AddrWidth-1:0] chk_idx_q, chk_idx_d;
  logic                 hit_q, hit_d;
  logic                 have_free_q, have_free_d;
  logic [AddrWidth-1:0] hit_slot_q, hit_slot_d;
  logic [AddrWidth-1:0] free_slot_q, free_slot_d;
  flow_in_t             item_q, item_d;
  logic [TtlWidth-1:0]  ttl_q;

  logic                 ram_we;
  logic [AddrWidth-1:0] ram_waddr;
  entry_t               ram_wdata;
  entry_t               ram_rdata;
  logic [AddrWidth-1:0] ram_raddr;

  entry_t               new_entry;
  logic [31:0]          age_diff;
  logic                 expired;
  logic                 live;
  logic                 match;
  logic                 accept;
  logic [AddrWidth-1:0] ins_slot;

  // Table storage
  ftd_ram #(
    .WIDTH (EntryWidth),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared compare unit: wrap-safe expiry and tuple match on the read entry
  assign age_diff = ram_rdata.seen_tick + {1'b0, ttl_q} - item_q.now_time;
  assign expired  = age_diff[31];
  assign live     = ram_rdata.valid && !expired;
  assign match    = (ram_rdata.src_addr == item_q.src_addr) &&
                    (ram_rdata.dst_addr == item_q.dst_addr) &&
                    (ram_rdata.port_pair == {item_q.src_port, item_q.dst_port}) &&
                    (ram_rdata.protocol == item_q.ip_protocol);

  assign new_entry = '{valid:     1'b1,
                       src_addr:  item_q.src_addr,
                       dst_addr:  item_q.dst_addr,
                       port_pair: {item_q.src_port, item_q.dst_port},
                       protocol:  item_q.ip_protocol,
                       seen_tick: item_q.now_time};

  assign accept    = start_i && !busy_o;
  assign ins_slot  = have_free_q ? free_slot_q : '0;
  assign ram_raddr = cnt_q[AddrWidth-1:0];

  // Sequencer: next state, counters and RAM write port
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = cnt_q[AddrWidth-1:0];
    hit_d       = hit_q;
    have_free_d = have_free_q;
    hit_slot_d  = hit_slot_q;
    free_slot_d = free_slot_q;
    item_d      = item_q;
    ram_we      = 1'b0;
    ram_waddr   = chk_idx_q;
    ram_wdata   = new_entry;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[AddrWidth-1:0];
        ram_wdata = '0;
        if (cnt_q == CntLast) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          item_d      = item_i;
          cnt_d       = '0;
          hit_d       = 1'b0;
          have_free_d = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue the next read
        if (cnt_q != CntEnd) begin
          chk_vld_d = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end
        // check the entry read last cycle
        if (chk_vld_q) begin
          if (live && match && !hit_q) begin
            ram_we     = 1'b1;
            hit_d      = 1'b1;
            hit_slot_d = chk_idx_q;
          end else if (ram_rdata.valid && expired) begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            ram_wdata.valid = 1'b0;
          end
          if (!live && !have_free_q) begin
            have_free_d = 1'b1;
            free_slot_d = chk_idx_q;
          end
          if (cnt_q == CntEnd) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        // insert on a miss
        ram_we    = !hit_q;
        ram_waddr = ins_slot;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      chk_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      have_free_q <= 1'b0;
      ttl_q       <= TtlReset;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_vld_q   <= chk_vld_d;
      hit_q       <= hit_d;
      have_free_q <= have_free_d;
      if (cfg_we_i) begin
        ttl_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    hit_slot_q  <= hit_slot_d;
    free_slot_q <= free_slot_d;
    item_q      <= item_d;
  end

  // Outputs
  assign busy_o                  = (state_q != ST_IDLE);
  assign result_valid_o          = (state_q == ST_FINISH);
  assign result_o.new_flow       = !hit_q;
  assign result_o.slot_index     = hit_q ? SlotWidth'(hit_slot_q) : SlotWidth'(ins_slot);
  assign result_o.overwrote_live = !hit_q && !have_free_q;

  // Checks
  `FTD_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `FTD_ASSERT_NEXT(a_result_pulse, result_valid_o, !result_valid_o)
  `FTD_ASSERT(a_overwrite_new, !result_valid_o || !result_o.overwrote_live || result_o.new_flow)
  `FTD_ASSERT_NEXT(a_hit_once, chk_vld_q && hit_q && (state_q == ST_SCAN), hit_q)

endmodule

// ===== hdl/ftd_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module ftd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== bench/flow_table_ttl_dedup_test.sv =====
// Self-checking testbench for the five-tuple flow table with idle aging.
`timescale 1ns / 1ps

module flow_table_ttl_dedup_test;
  import ftd_pkg::*;

  localparam int unsigned TableEntries = 256;
  localparam logic [TtlWidth-1:0] TtlMax = '1;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  flow_in_t            item_i;
  logic                result_valid_o;
  flow_out_t           result_o;
  logic                cfg_we_i;
  logic [TtlWidth-1:0] cfg_wdata_i;

  // Mirror of the flow table: ages, looks up and inserts as each item is accepted
  class flow_table_mirror;
    logic [TtlWidth-1:0] ttl;
    entry_t              tbl [TableEntries];
    flow_out_t           verdict_q [$];
    int unsigned         mismatch_cnt;

    function new();
      ttl = TtlReset;
      foreach (tbl[i]) tbl[i] = '0;
      mismatch_cnt = 0;
    endfunction

    function void set_ttl(logic [TtlWidth-1:0] v);
      ttl = v;
    endfunction

    function void flag(string what, flow_out_t want, flow_out_t got);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) begin
        $display("%t %s: want new=%b slot=%0d ovr=%b, got new=%b slot=%0d ovr=%b", $realtime,
                 what, want.new_flow, want.slot_index, want.overwrote_live,
                 got.new_flow, got.slot_index, got.overwrote_live);
      end
    endfunction

    // Work out the verdict for one accepted packet and update the table copy
    function void note_packet(flow_in_t p);
      logic [31:0] ports;
      logic [31:0] slack;
      int unsigned free_slot;
      bit          have_free;
      flow_out_t   v;
      ports = {p.src_port, p.dst_port};
      // age first: expired when seen_tick + ttl - now is negative, modulo 2^32
      foreach (tbl[i]) begin
        slack = tbl[i].seen_tick + {1'b0, ttl} - p.now_time;
        if (tbl[i].valid && slack[31]) begin
          tbl[i].valid = 1'b0;
        end
      end
      have_free = 1'b0;
      free_slot = 0;
      // lookup; note the lowest free slot on the way
      for (int i = 0; i < TableEntries; i++) begin
        if (!tbl[i].valid) begin
          if (!have_free) begin
            have_free = 1'b1;
            free_slot = i;
          end
        end else if (tbl[i].src_addr == p.src_addr && tbl[i].dst_addr == p.dst_addr &&
                     tbl[i].port_pair == ports && tbl[i].protocol == p.ip_protocol) begin
          tbl[i].seen_tick = p.now_time;
          v.new_flow       = 1'b0;
          v.slot_index     = SlotWidth'(i);
          v.overwrote_live = 1'b0;
          verdict_q.push_back(v);
          return;
        end
      end
      // miss: insert, slot 0 when the table is full
      tbl[free_slot] = '{valid: 1'b1, src_addr: p.src_addr, dst_addr: p.dst_addr,
                         port_pair: ports, protocol: p.ip_protocol, seen_tick: p.now_time};
      v.new_flow       = 1'b1;
      v.slot_index     = SlotWidth'(free_slot);
      v.overwrote_live = !have_free;
      verdict_q.push_back(v);
    endfunction

    function void check_verdict(flow_out_t got);
      flow_out_t want;
      if (verdict_q.size() == 0) begin
        flag("unexpected result", 'x, got);
        return;
      end
      want = verdict_q.pop_front();
      if (got.new_flow !== want.new_flow || got.slot_index !== want.slot_index ||
          got.overwrote_live !== want.overwrote_live) begin
        flag("mismatch", want, got);
      end
    endfunction

    function void flag_leftovers();
      while (verdict_q.size() != 0) flag("result missing", verdict_q.pop_front(), 'x);
    endfunction
  endclass

  flow_table_mirror mirror;
  flow_in_t         flow_pool [$];
  logic [31:0]      now_tick;
  int unsigned      calm_left;

  flow_table_ttl_dedup #(
    .TABLE_ENTRIES(TableEntries)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o !== 1'b0) begin
      mirror.check_verdict(result_o);
    end
  end

  // Hard limit on run time
  initial begin
    #(50_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic flow_in_t random_tuple();
    flow_in_t t;
    t.src_addr    = $urandom;
    t.dst_addr    = $urandom;
    t.src_port    = 16'($urandom);
    t.dst_port    = 16'($urandom);
    t.ip_protocol = 8'($urandom);
    t.now_time    = $urandom;
    return t;
  endfunction

  // Present one item; called at a falling edge, returns at a falling edge with start still high
  task automatic drive_packet(flow_in_t p);
    start_i <= 1'b1;
    item_i  <= p;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    mirror.note_packet(p);
    @(negedge clk_i);
  endtask

  task automatic send_at(flow_in_t t, logic [31:0] at);
    t.now_time = at;
    drive_packet(t);
  endtask

  // Sender gap; the data bus carries junk while start is low
  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else if (r < 45) begin
      n = 0;
    end else if (r < 70) begin
      n = $urandom_range(1, 4);
    end else if (r < 82) begin
      n = $urandom_range(5, 200);
    end else if (r < 95) begin
      n = $urandom_range(250, 275);
    end else if (r < 98) begin
      n = $urandom_range(300, 600);
    end else begin
      calm_left = $urandom_range(10, 40);
    end
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) begin
        item_i <= random_tuple();
        @(negedge clk_i);
      end
    end
  endtask

  // Hold off until every expected result is back and the block is idle
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (mirror.verdict_q.size() != 0 || busy_o !== 1'b0);
  endtask

  task automatic write_ttl(logic [TtlWidth-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mirror.set_ttl(v);
  endtask

  // One ttl setting: a pool of flows revisited, fresh flows and near misses
  task automatic run_phase(logic [TtlWidth-1:0] ttl, int unsigned items, int unsigned step_max,
                           int unsigned new_pct, int unsigned pool_cap, bit jumps);
    flow_in_t    p;
    int unsigned r;
    int unsigned k;
    write_ttl(ttl);
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (flow_pool.size() == 0 || r < new_pct) begin
        p = random_tuple();
        flow_pool.push_back(p);
      end else begin
        p = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
        // near miss: one tuple bit flipped
        if (r < new_pct + 8) begin
          k = $urandom_range(32, $bits(flow_in_t) - 1);
          p[k] = ~p[k];
          flow_pool.push_back(p);
        end
      end
      if (flow_pool.size() > pool_cap) begin
        flow_pool.delete($urandom_range(0, flow_pool.size() - 1));
      end
      if (jumps && $urandom_range(0, 19) == 0) begin
        now_tick = $urandom;
      end else begin
        now_tick = now_tick + $urandom_range(0, step_max);
      end
      send_at(p, now_tick);
      if ($urandom_range(0, 199) == 0) begin
        drain();
      end else begin
        idle_gap();
      end
    end
  endtask

  // Stimulus
  initial begin
    flow_in_t    a;
    flow_in_t    b;
    flow_in_t    c;
    logic [30:0] rnd_ttl;
    mirror      = new();
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    now_tick    = 0;
    calm_left   = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset ttl, field extremes, wrap and expiry boundaries
    drain();
    a = '0;
    b = '1;
    send_at(a, 0);
    send_at(a, 0);
    send_at(b, 32'hFFFF_FFFF);
    c = a; c.src_port    = '1; send_at(c, 1);
    c = a; c.dst_port    = '1; send_at(c, 1);
    c = a; c.ip_protocol = '1; send_at(c, 1);
    c = a; c.src_addr    = '1; send_at(c, 1);
    c = a; c.dst_addr    = '1; send_at(c, 1);
    send_at(b, 5);
    send_at(a, 300000);
    send_at(a, 600000);
    send_at(b, 600000);
    send_at(a, 900001);
    // zero ttl: alive on its own tick only
    write_ttl('0);
    send_at(a, 900001);
    send_at(a, 900002);
    send_at(b, 0);
    // largest ttl, right at the boundary and past it
    write_ttl(TtlMax);
    send_at(a, 32'd900002 + 32'h7FFF_FFFF);
    send_at(b, 32'd900003 + 32'h7FFF_FFFF);

    // random phases
    now_tick = $urandom;
    run_phase(31'd1000, 300, 100, 30, 30, 1'b0);
    run_phase(TtlMax, 450, 50, 75, 400, 1'b0);
    run_phase(31'd1, 200, 2, 25, 10, 1'b0);
    rnd_ttl = 31'($urandom_range(32'h7FFF_FFFF, 1000));
    run_phase(rnd_ttl, 300, 32'(rnd_ttl / 31'd40), 40, 60, 1'b1);
    run_phase('0, 150, 1, 20, 8, 1'b0);
    run_phase(31'd50000, 300, 2000, 30, 40, 1'b1);

    // wind down
    drain();
    repeat (TableEntries + 8) @(negedge clk_i);
    mirror.flag_leftovers();
    if (mirror.mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ftd_pkg.sv
hdl/ftd_ram.sv
hdl/flow_table_ttl_dedup.sv
bench/flow_table_ttl_dedup_test.sv
